// File: hw/rtl/svge_pkg.sv
// ----------------------------------------------------------------------------
// svge_pkg: shared types and constants of the state vector gate engine
// Operation codes, sequencer state codes, packed amplitude helpers and the
// bundles passed between the sequencer, the multiply unit and the
// reciprocal square root unit.
// ----------------------------------------------------------------------------
package svge_pkg;

	localparam logic [2:0] OP_GATE  = 3'd0;
	localparam logic [2:0] OP_CGATE = 3'd1;
	localparam logic [2:0] OP_CNOT  = 3'd2;
	localparam logic [2:0] OP_MEAS  = 3'd3;
	localparam logic [2:0] OP_QUERY = 3'd4;

	// 1.0 + 0i in packed Q2.30
	localparam logic [63:0] AMP_ONE = 64'h4000_0000_0000_0000;
	localparam logic [7:0]  GCNT_WRAP = 8'd255;
	localparam logic [31:0] PROB_MAX = 32'h8000_0000;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_CLEAR = 9'b000000010,
		ST_GATE  = 9'b000000100,
		ST_SCAN  = 9'b000001000,
		ST_QUERY = 9'b000010000,
		ST_RECIP = 9'b000100000,
		ST_SCALE = 9'b001000000,
		ST_RESP  = 9'b010000000,
		ST_START = 9'b100000000
	} state_t;

	typedef enum logic [5:0] {
		R_IDLE  = 6'b000001,
		R_SHIFT = 6'b000010,
		R_SQRT  = 6'b000100,
		R_PREP  = 6'b001000,
		R_DIV   = 6'b010000,
		R_DONE  = 6'b100000
	} recip_state_t;

	typedef struct packed {
		logic signed [65:0] rr;
		logic signed [65:0] ii;
		logic signed [65:0] ri;
		logic signed [65:0] ir;
	} prod_t;

	typedef struct packed {
		logic        done;
		logic        zero;
		logic [32:0] inv;
	} recip_rsp_t;

	function automatic logic signed [33:0] ext34(input logic [31:0] v);
		ext34 = {{2{v[31]}}, v};
	endfunction

	// round to nearest (ties up), shift by 30, saturate to 32 bits
	function automatic logic [31:0] rnd_sat(input logic signed [65:0] v);
		logic signed [65:0] t;
		t = (v + 66'sd536870912) >>> 30;
		if (t > 66'sd2147483647)
			rnd_sat = 32'h7FFF_FFFF;
		else if (t < -66'sd2147483648)
			rnd_sat = 32'h8000_0000;
		else
			rnd_sat = t[31:0];
	endfunction

endpackage

// File: hw/rtl/svge_ram.sv
// ----------------------------------------------------------------------------
// svge_ram: generic single write, single read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module svge_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/svge_cmul.sv
// ----------------------------------------------------------------------------
// svge_cmul: shared complex product unit
// Forms the four cross products of a packed Q2.30 complex operand and a
// 34-bit signed complex operand, registered. Serves gate products,
// squared magnitudes and the renormalization scale.
// ----------------------------------------------------------------------------
module svge_cmul (
	input  logic                 clk,
	input  logic [63:0]          a,
	input  logic signed [33:0]   x_re,
	input  logic signed [33:0]   x_im,
	output svge_pkg::prod_t      prod
);

	logic signed [31:0] a_re;
	logic signed [31:0] a_im;

	assign a_re = a[63:32];
	assign a_im = a[31:0];

	always_ff @(posedge clk) begin
		prod.rr <= 66'(a_re * x_re);
		prod.ii <= 66'(a_im * x_im);
		prod.ri <= 66'(a_re * x_im);
		prod.ir <= 66'(a_im * x_re);
	end

endmodule

// File: hw/rtl/svge_recip.sv
// ----------------------------------------------------------------------------
// svge_recip: reciprocal square root sequencer for renormalization
// Scales the norm sum by an even power of two, takes a 31-step digit
// square root, then a 62-step restoring division for the reciprocal.
// ----------------------------------------------------------------------------
module svge_recip #(
	parameter int SW = 74
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SW-1:0]          sum,
	output svge_pkg::recip_rsp_t   rsp
);

	svge_pkg::recip_state_t state_q;
	logic [SW-1:0] sh_q;
	logic [60:0]   num_q;
	logic [63:0]   x_q;
	logic [63:0]   r_q;
	logic [63:0]   bit_q;
	logic [61:0]   dvd_q;
	logic [31:0]   rem_q;
	logic [5:0]    cnt_q;
	logic          zero_q;
	logic [63:0]   rb;
	logic [32:0]   trial;

	assign rb    = r_q + bit_q;
	assign trial = {rem_q, dvd_q[61]};

	assign rsp.done = (state_q == svge_pkg::R_DONE);
	assign rsp.zero = zero_q;
	assign rsp.inv  = (dvd_q > 62'h1_0000_0000) ? 33'h1_0000_0000 : dvd_q[32:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svge_pkg::R_IDLE;
			cnt_q   <= '0;
			zero_q  <= 1'b0;
		end else begin
			case (state_q)
				svge_pkg::R_IDLE: begin
					if (start) begin
						sh_q  <= sum;
						num_q <= 61'h1000_0000_0000_0000;
						if (sum == '0) begin
							zero_q  <= 1'b1;
							state_q <= svge_pkg::R_DONE;
						end else begin
							zero_q  <= 1'b0;
							state_q <= svge_pkg::R_SHIFT;
						end
					end
				end
				svge_pkg::R_SHIFT: begin
					if (|sh_q[SW-1:62]) begin
						sh_q  <= sh_q >> 2;
						num_q <= num_q >> 1;
					end else begin
						x_q     <= {2'b00, sh_q[61:0]};
						r_q     <= '0;
						bit_q   <= 64'h1000_0000_0000_0000;
						cnt_q   <= '0;
						state_q <= svge_pkg::R_SQRT;
					end
				end
				svge_pkg::R_SQRT: begin
					if (x_q >= rb) begin
						x_q <= x_q - rb;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd30)
						state_q <= svge_pkg::R_PREP;
				end
				svge_pkg::R_PREP: begin
					if (r_q == '0) begin
						zero_q  <= 1'b1;
						state_q <= svge_pkg::R_DONE;
					end else begin
						dvd_q   <= 62'(num_q) + r_q[62:1];
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= svge_pkg::R_DIV;
					end
				end
				svge_pkg::R_DIV: begin
					// dividend bits shift out the top, quotient bits in at the bottom
					if (trial >= r_q[32:0]) begin
						rem_q <= 32'(trial - r_q[32:0]);
						dvd_q <= {dvd_q[60:0], 1'b1};
					end else begin
						rem_q <= trial[31:0];
						dvd_q <= {dvd_q[60:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd61)
						state_q <= svge_pkg::R_DONE;
				end
				svge_pkg::R_DONE: begin
					state_q <= svge_pkg::R_IDLE;
				end
				default: begin
					state_q <= svge_pkg::R_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/state_vector_gate_engine.sv
// ----------------------------------------------------------------------------
// state_vector_gate_engine: state vector simulator with a sequenced datapath
// Keeps 2^NUM_QUBITS packed Q2.30 complex amplitudes in one RAM and applies
// one operation per input transfer.
// Channels: one input item (operation, qubits, gate matrix, random fraction,
// collapse flag, basis index) and one result item (measured_index,
// probability) per operation, both valid/ready. in_ready is high only while
// the sequencer is idle; the result sits in an output register, so a stalled
// receiver holds only the next operation's completion, not its start.
// Operations run one at a time through the single RAM read port and the one
// shared complex product unit. A measurement scans entries up to the hit
// and, when collapsing, then rewrites the RAM to the measured basis state.
// Every 256th gate or controlled gate (controlled NOTs do not count) is
// followed by a renormalization pass.
// Reset: a clearing pass writes basis state zero into the RAM;
// in_ready stays low until it is done.
// ----------------------------------------------------------------------------
module state_vector_gate_engine #(
	parameter int NUM_QUBITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [3:0]  target_qubit,
	input  logic [3:0]  control_qubit,
	input  logic [63:0] coeff_00,
	input  logic [63:0] coeff_01,
	input  logic [63:0] coeff_10,
	input  logic [63:0] coeff_11,
	input  logic [31:0] random_fraction,
	input  logic        collapse_enable,
	input  logic [9:0]  query_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  measured_index,
	output logic [31:0] probability
);

	localparam int AW    = NUM_QUBITS;
	localparam int DEPTH = 1 << AW;
	localparam int SW    = 64 + AW;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	svge_pkg::state_t state_q;
	logic [2:0]    step_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] one_q;
	logic [AW-1:0] tm_q;
	logic [AW-1:0] cm_q;
	logic          resp_q;
	logic [2:0]    op_q;
	logic [63:0]   coef_q [4];
	logic [31:0]   rnd_q;
	logic          collapse_q;
	logic [9:0]    basis_q;
	logic [63:0]   a0_q;
	logic [63:0]   a1_q;
	logic signed [65:0] acc_re_q;
	logic signed [65:0] acc_im_q;
	logic [63:0]   macc_q;
	logic [SW-1:0] sum_q;
	logic [7:0]    gcnt_q;
	logic [32:0]   inv_q;
	logic          recip_go_q;
	logic [9:0]    midx_q;
	logic [31:0]   prob_q;
	logic          out_valid_q;
	logic [9:0]    out_midx_q;
	logic [31:0]   out_prob_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [63:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [63:0]   ram_rdata;

	logic [63:0]        mul_a;
	logic signed [33:0] mul_xr;
	logic signed [33:0] mul_xi;
	svge_pkg::prod_t    prod;
	svge_pkg::recip_rsp_t rsp;

	logic [AW-1:0] jdx;
	logic          base;
	logic          is_swap;
	logic signed [65:0] p_re;
	logic signed [65:0] p_im;
	logic [63:0]   mag;
	logic [64:0]   macc_sum;
	logic [63:0]   macc_new;
	logic [63:0]   r60;
	logic [64:0]   prob_rnd;
	logic          basis_ok;
	logic          tq_ok;
	logic          cq_ok;
	logic          last;

	assign jdx      = idx_q | tm_q;
	assign base     = ((idx_q & tm_q) == '0) && ((idx_q & cm_q) == cm_q);
	assign is_swap  = (op_q == svge_pkg::OP_CNOT);
	assign p_re     = prod.rr - prod.ii;
	assign p_im     = prod.ri + prod.ir;
	assign mag      = prod.rr[63:0] + prod.ii[63:0];
	assign macc_sum = {1'b0, macc_q} + {1'b0, mag};
	assign macc_new = macc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : macc_sum[63:0];
	assign r60      = {4'h0, rnd_q, 28'h0};
	assign prob_rnd = ({1'b0, mag} + 65'h1000_0000) >> 29;
	assign basis_ok = ((32'(basis_q)) >> AW) == 32'd0;
	assign tq_ok    = 32'(target_qubit) < NUM_QUBITS;
	assign cq_ok    = 32'(control_qubit) < NUM_QUBITS;
	assign last     = (idx_q == LAST);

	assign in_ready       = (state_q == svge_pkg::ST_IDLE);
	assign out_valid      = out_valid_q;
	assign measured_index = out_midx_q;
	assign probability    = out_prob_q;

	svge_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	svge_cmul u_cmul (
		.clk  (clk),
		.a    (mul_a),
		.x_re (mul_xr),
		.x_im (mul_xi),
		.prod (prod)
	);

	svge_recip #(.SW(SW)) u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (recip_go_q),
		.sum    (sum_q),
		.rsp    (rsp)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		ram_raddr = idx_q;
		mul_a     = coef_q[0];
		mul_xr    = svge_pkg::ext34(a0_q[63:32]);
		mul_xi    = svge_pkg::ext34(a0_q[31:0]);
		case (state_q)
			svge_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = (idx_q == one_q) ? svge_pkg::AMP_ONE : 64'h0;
			end
			svge_pkg::ST_GATE: begin
				case (step_q)
					3'd1: ram_raddr = jdx;
					3'd3: begin
						if (is_swap) begin
							ram_we    = 1'b1;
							ram_wdata = a1_q;
						end else begin
							mul_a  = coef_q[1];
							mul_xr = svge_pkg::ext34(a1_q[63:32]);
							mul_xi = svge_pkg::ext34(a1_q[31:0]);
						end
					end
					3'd4: begin
						if (is_swap) begin
							ram_we    = 1'b1;
							ram_waddr = jdx;
							ram_wdata = a0_q;
						end else begin
							mul_a = coef_q[2];
						end
					end
					3'd5: begin
						mul_a     = coef_q[3];
						mul_xr    = svge_pkg::ext34(a1_q[63:32]);
						mul_xi    = svge_pkg::ext34(a1_q[31:0]);
						ram_we    = 1'b1;
						ram_wdata = {svge_pkg::rnd_sat(acc_re_q), svge_pkg::rnd_sat(acc_im_q)};
					end
					3'd7: begin
						ram_we    = 1'b1;
						ram_waddr = jdx;
						ram_wdata = {svge_pkg::rnd_sat(acc_re_q), svge_pkg::rnd_sat(acc_im_q)};
					end
					default: ;
				endcase
			end
			svge_pkg::ST_SCAN, svge_pkg::ST_QUERY: begin
				if (state_q == svge_pkg::ST_QUERY)
					ram_raddr = AW'(basis_q);
				mul_a  = ram_rdata;
				mul_xr = svge_pkg::ext34(ram_rdata[63:32]);
				mul_xi = svge_pkg::ext34(ram_rdata[31:0]);
			end
			svge_pkg::ST_SCALE: begin
				mul_a  = ram_rdata;
				mul_xr = 34'(inv_q);
				mul_xi = 34'(inv_q);
				if (step_q == 3'd2) begin
					ram_we    = 1'b1;
					ram_wdata = {svge_pkg::rnd_sat(prod.rr), svge_pkg::rnd_sat(prod.ii)};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= svge_pkg::ST_CLEAR;
			step_q      <= '0;
			idx_q       <= '0;
			one_q       <= '0;
			resp_q      <= 1'b0;
			gcnt_q      <= '0;
			recip_go_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			recip_go_q <= 1'b0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				svge_pkg::ST_IDLE: begin
					if (in_valid) begin
						op_q       <= operation;
						coef_q[0]  <= coeff_00;
						coef_q[1]  <= coeff_01;
						coef_q[2]  <= coeff_10;
						coef_q[3]  <= coeff_11;
						rnd_q      <= random_fraction;
						collapse_q <= collapse_enable;
						basis_q    <= query_index;
						tm_q       <= AW'(1) << target_qubit;
						cm_q       <= (operation == svge_pkg::OP_GATE) ? '0
						              : AW'(1) << control_qubit;
						midx_q     <= '0;
						prob_q     <= '0;
						macc_q     <= '0;
						idx_q      <= '0;
						step_q     <= '0;
						state_q    <= svge_pkg::ST_RESP;
						case (operation)
							svge_pkg::OP_GATE: begin
								if (tq_ok)
									state_q <= svge_pkg::ST_GATE;
							end
							svge_pkg::OP_CGATE, svge_pkg::OP_CNOT: begin
								if (tq_ok && cq_ok && target_qubit != control_qubit)
									state_q <= svge_pkg::ST_GATE;
							end
							svge_pkg::OP_MEAS:  state_q <= svge_pkg::ST_SCAN;
							svge_pkg::OP_QUERY: state_q <= svge_pkg::ST_QUERY;
							default: ;
						endcase
					end
				end
				svge_pkg::ST_CLEAR: begin
					idx_q <= idx_q + AW'(1);
					if (last)
						state_q <= resp_q ? svge_pkg::ST_RESP : svge_pkg::ST_IDLE;
				end
				svge_pkg::ST_GATE: begin
					step_q <= step_q + 3'd1;
					case (step_q)
						3'd1: a0_q <= ram_rdata;
						3'd2: a1_q <= ram_rdata;
						3'd3: begin
							acc_re_q <= p_re;
							acc_im_q <= p_im;
						end
						3'd4: begin
							acc_re_q <= acc_re_q + p_re;
							acc_im_q <= acc_im_q + p_im;
						end
						3'd5: begin
							acc_re_q <= p_re;
							acc_im_q <= p_im;
						end
						3'd6: begin
							acc_re_q <= acc_re_q + p_re;
							acc_im_q <= acc_im_q + p_im;
						end
						default: ;
					endcase
					// skip non-pair indices; a swap ends after its second write
					if ((step_q == 3'd0 && !base) || (step_q == 3'd4 && is_swap)
					    || step_q == 3'd7) begin
						step_q <= '0;
						idx_q  <= idx_q + AW'(1);
						if (last) begin
							idx_q   <= '0;
							state_q <= svge_pkg::ST_RESP;
							if (!is_swap) begin
								gcnt_q <= gcnt_q + 8'd1;
								if (gcnt_q == svge_pkg::GCNT_WRAP) begin
									sum_q   <= '0;
									state_q <= svge_pkg::ST_SCAN;
								end
							end
						end
					end
				end
				svge_pkg::ST_SCAN: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd2) begin
						step_q <= '0;
						idx_q  <= idx_q + AW'(1);
						if (op_q == svge_pkg::OP_MEAS) begin
							macc_q <= macc_new;
							if (r60 <= macc_new || last) begin
								midx_q <= (r60 <= macc_new) ? 10'(idx_q) : '0;
								one_q  <= (r60 <= macc_new) ? idx_q : '0;
								idx_q  <= '0;
								resp_q <= 1'b1;
								state_q <= collapse_q ? svge_pkg::ST_CLEAR
								                      : svge_pkg::ST_RESP;
							end
						end else begin
							sum_q <= sum_q + SW'(mag);
							if (last) begin
								idx_q      <= '0;
								recip_go_q <= 1'b1;
								state_q    <= svge_pkg::ST_RECIP;
							end
						end
					end
				end
				svge_pkg::ST_QUERY: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd2) begin
						if (basis_ok)
							prob_q <= (prob_rnd > 65'(svge_pkg::PROB_MAX))
							          ? svge_pkg::PROB_MAX : prob_rnd[31:0];
						state_q <= svge_pkg::ST_RESP;
					end
				end
				svge_pkg::ST_RECIP: begin
					if (rsp.done) begin
						inv_q   <= rsp.inv;
						step_q  <= '0;
						state_q <= rsp.zero ? svge_pkg::ST_RESP : svge_pkg::ST_SCALE;
					end
				end
				svge_pkg::ST_SCALE: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd2) begin
						step_q <= '0;
						idx_q  <= idx_q + AW'(1);
						if (last)
							state_q <= svge_pkg::ST_RESP;
					end
				end
				svge_pkg::ST_RESP: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_midx_q  <= midx_q;
						out_prob_q  <= prob_q;
						resp_q      <= 1'b0;
						state_q     <= svge_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= svge_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/svge_checker.sv
// ----------------------------------------------------------------------------
// svge_checker: port-level checks of the state vector gate engine
// Watches the handshakes and result fields and is bound to the top level.
// ----------------------------------------------------------------------------
module svge_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [9:0]  measured_index,
	input logic [31:0] probability
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(measured_index)
		&& $stable(probability))
		else $error("result changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an operation is in progress");

	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && probability != 32'h0 |-> measured_index == 10'h0)
		else $error("probability and measured index both nonzero");

	a_prob_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(probability[31] && probability[30:0] != 31'h0))
		else $error("probability above one");

endmodule

bind state_vector_gate_engine svge_checker u_svge_checker (.*);

// File: tb/sv/svge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svge_scoreboard: result predictor and scoreboard for the gate engine
// Watches the input and result channels, keeps its own copy of the amplitude
// store and gate counter, predicts one result per input transfer and compares
// every result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module svge_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [3:0]  target_qubit,
	input  logic [3:0]  control_qubit,
	input  logic [63:0] coeff_00,
	input  logic [63:0] coeff_01,
	input  logic [63:0] coeff_10,
	input  logic [63:0] coeff_11,
	input  logic [31:0] random_fraction,
	input  logic        collapse_enable,
	input  logic [9:0]  query_index,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [9:0]  measured_index,
	input  logic [31:0] probability,
	output int          fail_count,
	output int          pending
);

	localparam int NQ    = 10;
	localparam int DEPTH = 1 << NQ;

	typedef struct packed {
		logic [9:0]  idx;
		logic [31:0] prob;
	} outcome_t;

	logic [63:0] amps [DEPTH];
	logic [7:0]  gate_count;
	outcome_t    outcome_q [$];

	function automatic longint re_of(input logic [63:0] v);
		re_of = longint'($signed(v[63:32]));
	endfunction

	function automatic longint im_of(input logic [63:0] v);
		im_of = longint'($signed(v[31:0]));
	endfunction

	function automatic longint sat32(input longint x);
		if (x > 64'sd2147483647)
			sat32 = 64'sd2147483647;
		else if (x < -64'sd2147483648)
			sat32 = -64'sd2147483648;
		else
			sat32 = x;
	endfunction

	function automatic logic [63:0] pack_amp(input longint re, input longint im);
		pack_amp = {re[31:0], im[31:0]};
	endfunction

	function automatic longint unsigned mag_sq(input logic [63:0] v);
		longint r, i;
		r = re_of(v);
		i = im_of(v);
		mag_sq = longint'(r * r) + longint'(i * i);
	endfunction

	// exact sum of four Q4.60 products, rounded to Q2.30
	function automatic longint sum_round(input longint p0, p1, p2, p3);
		longint hs, ls;
		hs = (p0 >>> 30) + (p1 >>> 30) + (p2 >>> 30) + (p3 >>> 30);
		ls = (p0 & 64'sh3FFF_FFFF) + (p1 & 64'sh3FFF_FFFF)
			+ (p2 & 64'sh3FFF_FFFF) + (p3 & 64'sh3FFF_FFFF);
		sum_round = sat32(hs + ((ls + 64'sd536870912) >>> 30));
	endfunction

	function automatic logic [63:0] row_mac(input logic [63:0] u, a0, w, a1);
		longint ur, ui, wr, wi, xr, xi, yr, yi;
		ur = re_of(u); ui = im_of(u); wr = re_of(w); wi = im_of(w);
		xr = re_of(a0); xi = im_of(a0); yr = re_of(a1); yi = im_of(a1);
		row_mac = pack_amp(sum_round(ur * xr, -(ui * xi), wr * yr, -(wi * yi)),
			sum_round(ur * xi, ui * xr, wr * yi, wi * yr));
	endfunction

	function automatic void renormalize();
		logic [127:0]      total;
		longint unsigned   s, x, r, bitv, num, inv;
		longint            re, im;
		int                k;
		total = '0;
		for (int i = 0; i < DEPTH; i++)
			total += 128'(mag_sq(amps[i]));
		if (total == 0)
			return;
		k = 0;
		while ((total >> k) >= (128'd1 << 62))
			k += 2;
		s = 64'(total >> k);
		x = s;
		r = 0;
		bitv = 64'd1 << 60;
		for (int n = 0; n < 31; n++) begin
			if (x >= r + bitv) begin
				x -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		if (r == 0)
			return;
		num = 64'd1 << (60 - k / 2);
		inv = (num + r / 2) / r;
		if (inv > (64'd1 << 32))
			inv = 64'd1 << 32;
		for (int i = 0; i < DEPTH; i++) begin
			re = sat32((re_of(amps[i]) * longint'(inv) + 64'sd536870912) >>> 30);
			im = sat32((im_of(amps[i]) * longint'(inv) + 64'sd536870912) >>> 30);
			amps[i] = pack_amp(re, im);
		end
	endfunction

	function automatic void apply_matrix(input int tm, input int cm);
		logic [63:0] a0, a1;
		for (int i = 0; i < DEPTH; i++) begin
			if ((i & tm) == 0 && (i & cm) == cm) begin
				a0 = amps[i];
				a1 = amps[i | tm];
				amps[i]      = row_mac(coeff_00, a0, coeff_01, a1);
				amps[i | tm] = row_mac(coeff_10, a0, coeff_11, a1);
			end
		end
		gate_count = gate_count + 8'd1;
		if (gate_count == 0)
			renormalize();
	endfunction

	function automatic outcome_t predict();
		outcome_t        res;
		int              tm, cm;
		logic [63:0]     t;
		longint unsigned r60, acc, m, q;
		res = '0;
		tm = 1 << target_qubit;
		cm = 1 << control_qubit;
		case (operation)
			svge_pkg::OP_GATE: begin
				if (target_qubit < NQ)
					apply_matrix(tm, 0);
			end
			svge_pkg::OP_CGATE, svge_pkg::OP_CNOT: begin
				if (target_qubit < NQ && control_qubit < NQ && target_qubit != control_qubit) begin
					if (operation == svge_pkg::OP_CGATE) begin
						apply_matrix(tm, cm);
					end else begin
						for (int i = 0; i < DEPTH; i++) begin
							if ((i & cm) != 0 && (i & tm) == 0) begin
								t = amps[i];
								amps[i] = amps[i | tm];
								amps[i | tm] = t;
							end
						end
					end
				end
			end
			svge_pkg::OP_MEAS: begin
				r60 = longint'(random_fraction) << 28;
				acc = 0;
				for (int i = 0; i < DEPTH; i++) begin
					m = mag_sq(amps[i]);
					acc = (acc > ~m) ? '1 : acc + m;
					if (r60 <= acc) begin
						res.idx = 10'(i);
						break;
					end
				end
				if (collapse_enable) begin
					foreach (amps[i])
						amps[i] = '0;
					amps[res.idx] = svge_pkg::AMP_ONE;
				end
			end
			svge_pkg::OP_QUERY: begin
				q = (mag_sq(amps[query_index]) + (64'd1 << 28)) >> 29;
				res.prob = (q > longint'(svge_pkg::PROB_MAX)) ? svge_pkg::PROB_MAX : q[31:0];
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		int       errs;
		errs = 0;
		if (!arst_n) begin
			foreach (amps[i])
				amps[i] = '0;
			amps[0] = svge_pkg::AMP_ONE;
			gate_count = '0;
			outcome_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (outcome_q.size() == 0) begin
					$display("%0t: result transfer with nothing expected: index %0d prob %h",
						$time, measured_index, probability);
					errs++;
				end else begin
					want = outcome_q.pop_front();
					if (want.idx !== measured_index) begin
						$display("%0t: measured_index expected %0d actual %0d",
							$time, want.idx, measured_index);
						errs++;
					end
					if (want.prob !== probability) begin
						$display("%0t: probability expected %h actual %h",
							$time, want.prob, probability);
						errs++;
					end
				end
			end
			if (in_valid && in_ready)
				outcome_q.push_back(predict());
			fail_count <= fail_count + errs;
			pending <= outcome_q.size();
		end
	end

endmodule

// File: tb/sv/tb_state_vector_gate_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_state_vector_gate_engine: regression bench for the gate engine
// Drives directed corner operations, then random gate, measurement, query and
// invalid operation traffic over four throttling phases; a side checker
// predicts and scores every result.
// ----------------------------------------------------------------------------
module tb_state_vector_gate_engine;

	localparam int          LIMIT   = 30_000_000;
	localparam logic [31:0] HALF    = 32'd759250125;  // 1/sqrt(2) in Q2.30
	localparam logic [31:0] UNIT    = 32'h4000_0000;
	localparam logic [31:0] NEGUNIT = 32'hC000_0000;

	logic        clk;
	logic        arst_n;
	logic        in_valid, in_ready;
	logic [2:0]  operation;
	logic [3:0]  target_qubit, control_qubit;
	logic [63:0] coeff_00, coeff_01, coeff_10, coeff_11;
	logic [31:0] random_fraction;
	logic        collapse_enable;
	logic [9:0]  query_index;
	logic        out_valid, out_ready;
	logic [9:0]  measured_index;
	logic [31:0] probability;
	int          fail_count, pending;
	int          cycles;
	int          send_idle, recv_stall;
	int          op_count [8];

	state_vector_gate_engine dut (.*);

	svge_scoreboard u_checker (.*);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall);

	task automatic send_op(input logic [2:0] op, input logic [3:0] tq, cq,
		input logic [63:0] m00, m01, m10, m11, input logic [31:0] rf,
		input logic ce, input logic [9:0] bi);
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		target_qubit <= tq;
		control_qubit <= cq;
		coeff_00 <= m00;
		coeff_01 <= m01;
		coeff_10 <= m10;
		coeff_11 <= m11;
		random_fraction <= rf;
		collapse_enable <= ce;
		query_index <= bi;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		op_count[op]++;
	endtask

	task automatic send_gate(input logic [2:0] op, input logic [3:0] tq, cq,
		input logic [63:0] m00, m01, m10, m11);
		send_op(op, tq, cq, m00, m01, m10, m11, $urandom, 1'($urandom_range(1)),
			10'($urandom));
	endtask

	task automatic send_measure(input logic [31:0] rf, input logic ce);
		send_op(svge_pkg::OP_MEAS, 4'($urandom), 4'($urandom), {$urandom, $urandom},
			'0, '0, '0, rf, ce, 10'($urandom));
	endtask

	task automatic send_query(input logic [9:0] bi);
		send_op(svge_pkg::OP_QUERY, 4'($urandom), 4'($urandom), '0, '0, '0,
			{$urandom, $urandom}, $urandom, 1'($urandom_range(1)), bi);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [3:0] pick_qubit();
		pick_qubit = ($urandom_range(99) < 6) ? 4'($urandom_range(15, 10))
			: 4'($urandom_range(9));
	endfunction

	function automatic logic [63:0] rnd_coeff();
		rnd_coeff = {32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000),
			32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000)};
	endfunction

	task automatic random_item();
		int          sel, kind;
		logic [3:0]  tq, cq;
		logic [63:0] m [4];
		sel = $urandom_range(99);
		tq = pick_qubit();
		cq = ($urandom_range(99) < 8) ? tq : pick_qubit();
		kind = $urandom_range(99);
		case (kind % 6)
			0: m = '{{HALF, 32'd0}, {HALF, 32'd0}, {HALF, 32'd0}, {-HALF, 32'd0}};
			1: m = '{64'd0, {UNIT, 32'd0}, {UNIT, 32'd0}, 64'd0};
			2: m = '{64'd0, {32'd0, NEGUNIT}, {32'd0, UNIT}, 64'd0};
			3: m = '{{UNIT, 32'd0}, 64'd0, 64'd0, {32'd0, UNIT}};
			default: m = '{{HALF, 32'd0}, {32'd0, HALF}, {32'd0, HALF}, {HALF, 32'd0}};
		endcase
		if (kind >= 92)
			m = '{{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}};
		else if (kind >= 75)
			m = '{rnd_coeff(), rnd_coeff(), rnd_coeff(), rnd_coeff()};
		else if (kind == 74)
			m = '{64'd0, 64'd0, 64'd0, 64'd0};
		if (sel < 35)
			send_gate(svge_pkg::OP_GATE, tq, cq, m[0], m[1], m[2], m[3]);
		else if (sel < 57)
			send_gate(svge_pkg::OP_CGATE, tq, cq, m[0], m[1], m[2], m[3]);
		else if (sel < 67)
			send_gate(svge_pkg::OP_CNOT, tq, cq, m[0], m[1], m[2], m[3]);
		else if (sel < 79)
			send_measure($urandom, 1'($urandom_range(1)));
		else if (sel < 96)
			send_query(10'($urandom_range(1023)));
		else
			send_op(3'(svge_pkg::OP_QUERY + $urandom_range(3, 1)), tq, cq,
				m[0], m[1], m[2], m[3], $urandom, 1'($urandom_range(1)), 10'($urandom));
	endtask

	initial begin
		int idle_pct [4];
		int stall_pct [4];
		idle_pct = '{0, 76, 0, 19};
		stall_pct = '{0, 0, 76, 19};
		cycles = 0;
		send_idle = 0;
		recv_stall = 0;
		foreach (op_count[i])
			op_count[i] = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = svge_pkg::OP_QUERY;
		target_qubit = '0;
		control_qubit = '0;
		coeff_00 = '0;
		coeff_01 = '0;
		coeff_10 = '0;
		coeff_11 = '0;
		random_fraction = '0;
		collapse_enable = 1'b0;
		query_index = '0;
		out_ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send_query(10'd0);
		send_query(10'd1023);
		send_gate(svge_pkg::OP_GATE, 4'd0, 4'd0, {HALF, 32'd0}, {HALF, 32'd0},
			{HALF, 32'd0}, {-HALF, 32'd0});
		send_gate(svge_pkg::OP_GATE, 4'd9, 4'd0, {HALF, 32'd0}, {HALF, 32'd0},
			{HALF, 32'd0}, {-HALF, 32'd0});
		send_query(10'd513);
		send_gate(svge_pkg::OP_CNOT, 4'd3, 4'd0, '0, '0, '0, '0);
		send_gate(svge_pkg::OP_CGATE, 4'd5, 4'd9, {32'd0, HALF}, {HALF, 32'd0},
			{HALF, 32'd0}, {32'd0, -HALF});
		send_gate(svge_pkg::OP_CGATE, 4'd4, 4'd4, '1, '1, '1, '1);
		send_gate(svge_pkg::OP_CNOT, 4'd7, 4'd7, '0, '0, '0, '0);
		send_gate(svge_pkg::OP_GATE, 4'd15, 4'd0, '1, '1, '1, '1);
		send_gate(svge_pkg::OP_CGATE, 4'd2, 4'd12, '1, '1, '1, '1);
		send_measure(32'd0, 1'b0);
		send_measure(32'hFFFF_FFFF, 1'b0);
		send_gate(svge_pkg::OP_GATE, 4'd1, 4'd0, {32'h7FFF_FFFF, 32'h7FFF_FFFF},
			{32'h7FFF_FFFF, 32'h8000_0000}, {32'h8000_0000, 32'h8000_0000},
			{32'h8000_0000, 32'h7FFF_FFFF});
		send_query(10'd2);
		send_measure(32'h8000_0000, 1'b1);
		for (int op = svge_pkg::OP_QUERY + 1; op < 8; op++)
			send_op(3'(op), 4'd15, 4'd15, '1, '1, '1, '1, '1, 1'b1, '1);
		send_gate(svge_pkg::OP_GATE, 4'd6, 4'd0, '0, '0, '0, '0);
		send_measure(32'd1, 1'b0);
		send_measure(32'd12345, 1'b1);
		send_query(10'd0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle = idle_pct[ph];
			recv_stall = stall_pct[ph];
			repeat (140)
				random_item();
			// let the engine finish everything before the next phase
			drain();
		end

		repeat (50) @(posedge clk);
		$display("Covered %0d gates, %0d controlled gates, %0d controlled NOTs,",
			op_count[svge_pkg::OP_GATE], op_count[svge_pkg::OP_CGATE],
			op_count[svge_pkg::OP_CNOT]);
		$display("%0d measurements and %0d probability queries in %0d cycles.",
			op_count[svge_pkg::OP_MEAS], op_count[svge_pkg::OP_QUERY], cycles);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
